// ===== rtl/lfc_pkg.sv =====
package lfc_pkg;

    localparam int NUM_LETTERS   = 26;
    localparam int NUM_LANGUAGES = 4;
    localparam int COUNT_BITS    = 24;

    localparam int SHARE_BITS  = 14;
    localparam int PROD_BITS   = COUNT_BITS + SHARE_BITS;
    localparam int SQ_BITS     = 2 * SHARE_BITS;
    localparam int DIST_BITS   = 34;
    localparam int LETTER_W    = 5;
    localparam int LANG_W      = 2;
    localparam int TOTAL_W     = 24;
    localparam int DIV_CNT_W   = 4;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX   = {COUNT_BITS{1'b1}};
    localparam logic [SHARE_BITS-1:0] SHARE_SCALE = SHARE_BITS'(10000);

    localparam logic CMD_TEXT     = 1'b0;
    localparam logic CMD_CLASSIFY = 1'b1;

    localparam logic [SHARE_BITS-1:0] PROFILE [4][26] = '{
        '{14'd827, 14'd148, 14'd294, 14'd403, 14'd1178, 14'd222, 14'd172, 14'd677,
          14'd739, 14'd12, 14'd81, 14'd376, 14'd285, 14'd671, 14'd779, 14'd154,
          14'd5, 14'd595, 14'd669, 14'd907, 14'd266, 14'd113, 14'd214, 14'd19,
          14'd189, 14'd3},
        '{14'd797, 14'd140, 14'd355, 14'd379, 14'd1689, 14'd102, 14'd100, 14'd75,
          14'd708, 14'd38, 14'd4, 14'd551, 14'd282, 14'd811, 14'd519, 14'd278,
          14'd101, 14'd669, 14'd835, 14'd722, 14'd609, 14'd135, 14'd2, 14'd54,
          14'd30, 14'd15},
        '{14'd950, 14'd111, 14'd153, 14'd530, 14'd894, 14'd174, 14'd357, 14'd394,
          14'd398, 14'd89, 14'd326, 14'd493, 14'd341, 14'd846, 14'd501, 14'd177,
          14'd0, 14'd673, 14'd556, 14'd920, 14'd194, 14'd242, 14'd0, 14'd5,
          14'd45, 14'd0},
        '{14'd512, 14'd195, 14'd357, 14'd507, 14'd1687, 14'd135, 14'd300, 14'd579,
          14'd863, 14'd19, 14'd114, 14'd368, 14'd312, 14'd1064, 14'd174, 14'd42,
          14'd1, 14'd630, 14'd699, 14'd519, 14'd392, 14'd77, 14'd179, 14'd1,
          14'd69, 14'd124}
    };

    typedef struct packed {
        logic       cmd;
        logic [7:0] ch;
    } t_in_item;

    typedef struct packed {
        logic [LANG_W-1:0]  language;
        logic [TOTAL_W-1:0] letter_total;
        logic               no_letters;
    } t_out_item;

    typedef struct packed {
        logic start;
        logic done;
    } t_div_ctrl;

    function automatic logic [SHARE_BITS-1:0] f_profile(
        input logic [LANG_W-1:0]   lang,
        input logic [LETTER_W-1:0] letter
    );
        return PROFILE[lang][letter];
    endfunction

endpackage

// ===== rtl/letter_frequency_language_classifier.sv =====
// A text word (cmd 0) keeps the block idle, so bytes may stream in back to back while busy
// is low. A classify word (cmd 1) holds busy high while each letter passes through the
// 14-step shared share divider and the squaring multiplier reused for all four profiles, then
// through the profile compare and output; the divider is skipped when no letters
// were seen. The result appears on o_result for exactly one cycle with o_valid high, and the
// receiver must take it then because it cannot stall the block; counts are clear afterward.
module letter_frequency_language_classifier
    import lfc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_in_item  i_item,
    output logic      o_busy,
    output logic      o_valid,
    output t_out_item o_result
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL  = 8'b0000_0010,
        S_DIV  = 8'b0000_0100,
        S_WAIT = 8'b0000_1000,
        S_SQR  = 8'b0001_0000,
        S_ACC  = 8'b0010_0000,
        S_CMP  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state                r_state, n_state;
    logic [COUNT_BITS-1:0] r_count [NUM_LETTERS];
    logic [COUNT_BITS-1:0] r_total;
    logic [PROD_BITS-1:0]  r_prod;
    logic [SHARE_BITS-1:0] r_share;
    logic [SQ_BITS-1:0]    r_sq;
    logic [DIST_BITS-1:0]  r_dist [NUM_LANGUAGES];
    logic [DIST_BITS-1:0]  r_best_sum;
    logic [LANG_W-1:0]     r_best;
    logic [LANG_W-1:0]     r_lang;
    logic [LETTER_W-1:0]   r_letter;
    logic                  r_valid;
    t_out_item             r_result;

    logic                  w_accept;
    logic                  w_is_lower, w_is_upper;
    logic [7:0]            w_offset;
    logic [LETTER_W-1:0]   w_idx;
    logic                  w_count_en;
    logic [SHARE_BITS-1:0] w_prof;
    logic [SHARE_BITS-1:0] w_diff;
    t_div_ctrl             w_div;
    logic [SHARE_BITS-1:0] w_quot;

    assign w_accept   = i_start && (r_state == S_IDLE);
    assign w_is_lower = (i_item.ch >= 8'h61) && (i_item.ch <= 8'h7A);
    assign w_is_upper = (i_item.ch >= 8'h41) && (i_item.ch <= 8'h5A);
    assign w_offset   = w_is_lower ? (i_item.ch - 8'h61) : (i_item.ch - 8'h41);
    assign w_idx      = w_offset[LETTER_W-1:0];
    assign w_count_en = w_accept && (i_item.cmd == CMD_TEXT) && (w_is_lower || w_is_upper)
                        && (32'(w_idx) < NUM_LETTERS);

    assign w_prof = f_profile(r_lang, r_letter);
    assign w_diff = (w_prof >= r_share) ? (w_prof - r_share) : (r_share - w_prof);

    assign w_div.start = (r_state == S_DIV);

    lfc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div.start),
        .i_num   (r_prod),
        .i_den   (r_total),
        .o_done  (w_div.done),
        .o_quot  (w_quot)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_item.cmd == CMD_CLASSIFY)) begin
                    n_state = S_MUL;
                end
            end
            S_MUL:  n_state = (r_total == '0) ? S_SQR : S_DIV;
            S_DIV:  n_state = S_WAIT;
            S_WAIT: begin
                if (w_div.done) begin
                    n_state = S_SQR;
                end
            end
            S_SQR:  n_state = S_ACC;
            S_ACC: begin
                if (r_lang != LANG_W'(NUM_LANGUAGES - 1)) begin
                    n_state = S_SQR;
                end else if (r_letter == LETTER_W'(NUM_LETTERS - 1)) begin
                    n_state = S_CMP;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_CMP: begin
                if (r_lang == LANG_W'(NUM_LANGUAGES - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_total  <= '0;
            r_lang   <= '0;
            r_letter <= '0;
            r_valid  <= 1'b0;
            for (int i = 0; i < NUM_LETTERS; i++) begin
                r_count[i] <= '0;
            end
            for (int k = 0; k < NUM_LANGUAGES; k++) begin
                r_dist[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_count_en) begin
                        if (r_count[w_idx] != COUNT_MAX) begin
                            r_count[w_idx] <= r_count[w_idx] + 1'b1;
                        end
                        if (r_total != COUNT_MAX) begin
                            r_total <= r_total + 1'b1;
                        end
                    end
                    if (w_accept && (i_item.cmd == CMD_CLASSIFY)) begin
                        r_lang   <= '0;
                        r_letter <= '0;
                        for (int k = 0; k < NUM_LANGUAGES; k++) begin
                            r_dist[k] <= '0;
                        end
                    end
                end
                S_MUL: begin
                    r_prod  <= r_count[0] * SHARE_SCALE;
                    r_share <= '0;
                end
                S_DIV: begin
                end
                S_WAIT: begin
                    if (w_div.done) begin
                        r_share <= w_quot;
                    end
                end
                S_SQR: begin
                    r_sq <= w_diff * w_diff;
                end
                S_ACC: begin
                    r_dist[r_lang] <= r_dist[r_lang] + DIST_BITS'(r_sq);
                    if (r_lang != LANG_W'(NUM_LANGUAGES - 1)) begin
                        r_lang <= r_lang + 1'b1;
                    end else begin
                        r_lang   <= '0;
                        r_letter <= r_letter + 1'b1;
                        for (int i = 0; i < NUM_LETTERS - 1; i++) begin
                            r_count[i] <= r_count[i + 1];
                        end
                        r_count[NUM_LETTERS - 1] <= '0;
                    end
                end
                S_CMP: begin
                    if (r_lang == '0) begin
                        r_best_sum <= r_dist[0];
                        r_best     <= '0;
                    end else if (r_dist[r_lang] < r_best_sum) begin
                        r_best_sum <= r_dist[r_lang];
                        r_best     <= r_lang;
                    end
                    if (r_lang != LANG_W'(NUM_LANGUAGES - 1)) begin
                        r_lang <= r_lang + 1'b1;
                    end
                end
                S_DONE: begin
                    r_valid <= 1'b1;
                    r_total <= '0;
                end
                default: begin
                end
            endcase
        end
        if (r_state == S_DONE) begin
            r_result.language     <= r_best;
            r_result.letter_total <= TOTAL_W'(r_total);
            r_result.no_letters   <= (r_total == '0);
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    a_valid_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_DONE))
        else $error("Result strobe without a finished classify.");

    a_empty_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.no_letters) |-> (o_result.letter_total == '0))
        else $error("No-letters flag set with a nonzero letter total.");

    a_counts_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_count[0] == '0))
        else $error("Letter counts not cleared by the classify pass.");

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> (r_state == S_WAIT))
        else $error("Divider finished outside its wait state.");

endmodule

// ===== rtl/lfc_div.sv =====
module lfc_div
    import lfc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [PROD_BITS-1:0]  i_num,
    input  logic [COUNT_BITS-1:0] i_den,
    output logic                  o_done,
    output logic [SHARE_BITS-1:0] o_quot
);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [DIV_CNT_W-1:0]  r_cnt, n_cnt;
    logic [COUNT_BITS-1:0] r_rem, n_rem;
    logic [SHARE_BITS-1:0] r_low, n_low;
    logic [SHARE_BITS-1:0] r_quot, n_quot;
    logic [COUNT_BITS-1:0] r_den, n_den;
    logic [COUNT_BITS:0]   w_trial;
    logic [COUNT_BITS:0]   w_diff;
    logic                  w_ge;

    assign w_trial = {r_rem, r_low[SHARE_BITS-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_low  = r_low;
        n_quot = r_quot;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = i_num[PROD_BITS-1:SHARE_BITS];
            n_low  = i_num[SHARE_BITS-1:0];
            n_den  = i_den;
            n_quot = '0;
        end else if (r_busy) begin
            n_rem  = w_ge ? w_diff[COUNT_BITS-1:0] : w_trial[COUNT_BITS-1:0];
            n_low  = {r_low[SHARE_BITS-2:0], 1'b0};
            n_quot = {r_quot[SHARE_BITS-2:0], w_ge};
            n_cnt  = r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(SHARE_BITS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_low  <= n_low;
        r_quot <= n_quot;
        r_den  <= n_den;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    import lfc_pkg::*;

    localparam logic [7:0] UPPER_A = 8'h41;
    localparam logic [7:0] UPPER_Z = 8'h5A;
    localparam logic [7:0] LOWER_A = 8'h61;
    localparam logic [7:0] LOWER_Z = 8'h7A;

    localparam logic [LANG_W-1:0] LANG_ENGLISH = 2'd0;
    localparam logic [LANG_W-1:0] LANG_FRENCH  = 2'd1;
    localparam logic [LANG_W-1:0] LANG_SWEDISH = 2'd2;
    localparam logic [LANG_W-1:0] LANG_GERMAN  = 2'd3;

    localparam int IN_W          = $bits(t_in_item);
    localparam int NUM_DIRECTED  = 21;
    localparam int TARGET_ITEMS  = 1350;
    localparam int MIN_CLASSIFY  = 60;
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        logic       cmd;
        logic [7:0] ch;
        bit         typed;
        t_out_item  want;
    } t_stim_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_start;
    t_in_item  i_item;
    logic      o_busy;
    logic      o_valid;
    t_out_item o_result;

    letter_frequency_language_classifier dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_item   (i_item),
        .o_busy   (o_busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    logic [COUNT_BITS-1:0] letter_tally [NUM_LETTERS];
    logic [COUNT_BITS-1:0] letter_total;
    t_out_item             expected_results [$];

    int n_errors   = 0;
    int n_words    = 0;
    int n_letters  = 0;
    int n_classify = 0;
    int n_empty    = 0;
    int lang_hits [NUM_LANGUAGES];

    t_stim_row directed_rows [NUM_DIRECTED] = '{
        '{CMD_CLASSIFY, 8'h00, 1'b1, '{LANG_SWEDISH, 24'd0, 1'b1}},
        '{CMD_CLASSIFY, 8'hFF, 1'b1, '{LANG_SWEDISH, 24'd0, 1'b1}},
        '{CMD_TEXT,     8'h41, 1'b0, '0},
        '{CMD_CLASSIFY, 8'h00, 1'b1, '{LANG_SWEDISH, 24'd1, 1'b0}},
        '{CMD_TEXT,     8'h7A, 1'b0, '0},
        '{CMD_CLASSIFY, 8'h00, 1'b1, '{LANG_GERMAN, 24'd1, 1'b0}},
        '{CMD_TEXT,     8'h00, 1'b0, '0},
        '{CMD_TEXT,     8'hFF, 1'b0, '0},
        '{CMD_TEXT,     8'h40, 1'b0, '0},
        '{CMD_TEXT,     8'h5B, 1'b0, '0},
        '{CMD_TEXT,     8'h60, 1'b0, '0},
        '{CMD_TEXT,     8'h7B, 1'b0, '0},
        '{CMD_TEXT,     8'h80, 1'b0, '0},
        '{CMD_CLASSIFY, 8'h00, 1'b1, '{LANG_SWEDISH, 24'd0, 1'b1}},
        '{CMD_TEXT,     8'h61, 1'b0, '0},
        '{CMD_TEXT,     8'h5A, 1'b0, '0},
        '{CMD_TEXT,     8'h65, 1'b0, '0},
        '{CMD_TEXT,     8'h45, 1'b0, '0},
        '{CMD_TEXT,     8'h71, 1'b0, '0},
        '{CMD_TEXT,     8'h4D, 1'b0, '0},
        '{CMD_CLASSIFY, 8'h00, 1'b0, '0}
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $error("Timeout: the run did not finish in time.");
        $display("Test completed with failures");
        $finish;
    end

    function automatic void count_text(input logic [7:0] c);
        int idx;
        idx = -1;
        if (c >= LOWER_A && c <= LOWER_Z) begin
            idx = int'(c - LOWER_A);
        end else if (c >= UPPER_A && c <= UPPER_Z) begin
            idx = int'(c - UPPER_A);
        end
        if (idx >= 0 && idx < NUM_LETTERS) begin
            if (letter_tally[idx] != COUNT_MAX) begin
                letter_tally[idx] = letter_tally[idx] + 1'b1;
            end
            if (letter_total != COUNT_MAX) begin
                letter_total = letter_total + 1'b1;
            end
            n_letters++;
        end
    endfunction

    function automatic t_out_item classify_text();
        logic [DIST_BITS-1:0] dist_sum [NUM_LANGUAGES];
        longint unsigned      share;
        longint unsigned      diff;
        longint unsigned      acc;
        t_out_item            res;
        int                   best;
        for (int l = 0; l < NUM_LANGUAGES; l++) begin
            acc = 0;
            for (int j = 0; j < NUM_LETTERS; j++) begin
                share = (letter_total == 0) ? 64'd0 :
                        (64'(letter_tally[j]) * 64'd10000) / 64'(letter_total);
                diff = (64'(PROFILE[l][j]) >= share) ? 64'(PROFILE[l][j]) - share :
                                                      share - 64'(PROFILE[l][j]);
                acc += diff * diff;
            end
            dist_sum[l] = acc[DIST_BITS-1:0];
        end
        best = 0;
        for (int l = 1; l < NUM_LANGUAGES; l++) begin
            if (dist_sum[l] < dist_sum[best]) begin
                best = l;
            end
        end
        res.language     = LANG_W'(best);
        res.letter_total = letter_total;
        res.no_letters   = (letter_total == 0);
        if (letter_total == 0) begin
            n_empty++;
        end
        for (int j = 0; j < NUM_LETTERS; j++) begin
            letter_tally[j] = '0;
        end
        letter_total = '0;
        return res;
    endfunction

    function automatic int rand_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    task automatic send_word(input t_in_item w, input bit typed, input t_out_item want,
                             input int gap);
        t_out_item res;
        i_start <= 1'b1;
        i_item  <= w;
        do @(posedge i_clk); while (o_busy);
        n_words++;
        if (w.cmd == CMD_CLASSIFY) begin
            res = classify_text();
            expected_results = {expected_results, (typed ? want : res)};
            n_classify++;
        end else begin
            count_text(w.ch);
        end
        if (gap > 0) begin
            i_start <= 1'b0;
            i_item  <= t_in_item'(IN_W'($urandom));
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                $error("Result word with no expectation waiting: %p", o_result);
                n_errors++;
            end else begin
                want = expected_results.pop_front();
                if (o_result.language !== want.language) begin
                    $error("language: expected %0d, got %0d", want.language,
                           o_result.language);
                    n_errors++;
                end
                if (o_result.letter_total !== want.letter_total) begin
                    $error("letter_total: expected %0d, got %0d", want.letter_total,
                           o_result.letter_total);
                    n_errors++;
                end
                if (o_result.no_letters !== want.no_letters) begin
                    $error("no_letters: expected %0d, got %0d", want.no_letters,
                           o_result.no_letters);
                    n_errors++;
                end
                lang_hits[o_result.language]++;
            end
        end
    end

    initial begin
        int         lang;
        int         seg_len;
        int         weight_total;
        int         target;
        int         idx;
        int         r;
        bit         quiet;
        logic [7:0] ch;

        for (int l = 0; l < NUM_LANGUAGES; l++) begin
            lang_hits[l] = 0;
        end
        for (int j = 0; j < NUM_LETTERS; j++) begin
            letter_tally[j] = '0;
        end
        letter_total = '0;

        i_rst_n <= 1'b0;
        i_start <= 1'b0;
        i_item  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < NUM_DIRECTED; k++) begin
            send_word('{directed_rows[k].cmd, directed_rows[k].ch}, directed_rows[k].typed,
                      directed_rows[k].want, 0);
        end
        wait_drained();

        // Text is drawn from one profile's letter weights so that every language gets to win.
        while (n_words < TARGET_ITEMS || n_classify < MIN_CLASSIFY) begin
            lang  = $urandom_range(0, NUM_LANGUAGES - 1);
            quiet = ($urandom_range(0, 3) == 0);
            r     = $urandom_range(0, 99);
            if (r < 10) begin
                seg_len = 0;
            end else if (r < 85) begin
                seg_len = $urandom_range(1, 30);
            end else begin
                seg_len = $urandom_range(31, 150);
            end
            weight_total = 0;
            for (int j = 0; j < NUM_LETTERS; j++) begin
                weight_total += int'(PROFILE[lang][j]);
            end
            for (int k = 0; k < seg_len; k++) begin
                if ($urandom_range(0, 6) == 0) begin
                    ch = 8'($urandom);
                end else begin
                    target = $urandom_range(0, weight_total - 1);
                    idx    = 0;
                    while (target >= int'(PROFILE[lang][idx])) begin
                        target -= int'(PROFILE[lang][idx]);
                        idx++;
                    end
                    ch = 8'(idx) + (($urandom_range(0, 1) == 1) ? LOWER_A : UPPER_A);
                end
                send_word('{CMD_TEXT, ch}, 1'b0, '0, rand_gap(quiet));
            end
            send_word('{CMD_CLASSIFY, 8'($urandom)}, 1'b0, '0, rand_gap(quiet));
            if ($urandom_range(0, 9) == 0) begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d words: %0d letters counted, %0d classify commands (%0d with no letters).",
                 n_words, n_letters, n_classify, n_empty);
        $display("Best profile reported: English %0d, French %0d, Swedish %0d, German %0d.",
                 lang_hits[LANG_ENGLISH], lang_hits[LANG_FRENCH], lang_hits[LANG_SWEDISH],
                 lang_hits[LANG_GERMAN]);
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
